// ===== hdl/sorted_unique_index_set_unit_macros.svh =====
`ifndef SORTED_UNIQUE_INDEX_SET_UNIT_MACROS_SVH
`define SORTED_UNIQUE_INDEX_SET_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, idle in reset
`define SUSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, idle in reset
`define SUSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/susi_pkg.sv =====
package susi_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam int KEY_W    = 16;
    localparam int POS_W    = 10;
    localparam int FUNC_W   = 2;
    localparam int OCNT_W   = 11;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             was_new;
        logic             overflow;
        logic [KEY_W-1:0] read_value;
        logic             batch_done;
    } res_t;

endpackage

// ===== hdl/susi_ram.sv =====
module susi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/susi_seq.sv =====
`include "sorted_unique_index_set_unit_macros.svh"

module susi_seq
    import susi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [KEY_W-1:0]  row_index,
    input  logic [POS_W-1:0]  position,
    input  logic              last_of_batch,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_CMP    = 4'd2;
    localparam logic [3:0] ST_CHK    = 4'd3;
    localparam logic [3:0] ST_SHIFT  = 4'd4;
    localparam logic [3:0] ST_FLUSH  = 4'd5;
    localparam logic [3:0] ST_INS    = 4'd6;
    localparam logic [3:0] ST_RDV    = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              pend_reg, pend_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              last_reg, last_next;
    logic              was_new_reg, was_new_next;
    logic              ovf_reg, ovf_next;
    logic [KEY_W-1:0]  rval_reg, rval_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  mid_full;
    logic              accept;

    susi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign mid_full  = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign res.count      = count_reg;
    assign res.was_new    = was_new_reg;
    assign res.overflow   = ovf_reg;
    assign res.read_value = rval_reg;
    assign res.batch_done = last_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        ptr_next     = ptr_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        rd_ok_next   = rd_ok_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        was_new_next = was_new_reg;
        ovf_next     = ovf_reg;
        rval_next    = rval_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = ADDR_W'(position);
                if (accept)
                begin
                    key_next     = row_index;
                    last_next    = last_of_batch;
                    was_new_next = 1'b0;
                    ovf_next     = 1'b0;
                    rval_next    = '0;
                    lo_next      = '0;
                    hi_next      = count_reg;
                    rd_ok_next   = (32'(position) < 32'(count_reg));
                    priority if (func == FN_INSERT)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (func == FN_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (func == FN_READ)
                    begin
                        state_next = ST_RDV;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = ADDR_W'(mid_full);
                    ram_raddr  = ADDR_W'(mid_full);
                    state_next = ST_CMP;
                end
                else
                begin
                    ram_raddr  = ADDR_W'(lo_reg);
                    state_next = ST_CHK;
                end
            end
            ST_CMP:
            begin
                if (ram_rdata < key_reg)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                state_next = ST_SEARCH;
            end
            ST_CHK:
            begin
                priority if (lo_reg < count_reg && ram_rdata == key_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (count_reg == CNT_W'(MAX_ROWS))
                begin
                    was_new_next = 1'b1;
                    ovf_next     = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (lo_reg == count_reg)
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    ptr_next   = ADDR_W'(count_reg - CNT_W'(1));
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                ram_we       = pend_reg;
                ram_raddr    = ptr_reg;
                pend_next    = 1'b1;
                wr_addr_next = ptr_reg + ADDR_W'(1);
                if (ptr_reg == ADDR_W'(lo_reg))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    ptr_next = ptr_reg - ADDR_W'(1);
                end
            end
            ST_FLUSH:
            begin
                ram_we     = 1'b1;
                state_next = ST_INS;
            end
            ST_INS:
            begin
                ram_we       = 1'b1;
                ram_waddr    = ADDR_W'(lo_reg);
                ram_wdata    = key_reg;
                count_next   = count_reg + CNT_W'(1);
                was_new_next = 1'b1;
                state_next   = ST_DONE;
            end
            ST_RDV:
            begin
                rval_next  = rd_ok_reg ? ram_rdata : '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        rd_ok_reg   <= rd_ok_next;
        key_reg     <= key_next;
        last_reg    <= last_next;
        was_new_reg <= was_new_next;
        ovf_reg     <= ovf_next;
        rval_reg    <= rval_next;
    end

    `SUSI_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ROWS), "count above capacity")
    `SUSI_ASSERT_NOW(a_no_idle_write, state_reg == ST_IDLE, !ram_we, "store written while idle")
    `SUSI_ASSERT_NOW(a_search_order, state_reg == ST_SEARCH, lo_reg <= hi_reg, "search bounds crossed")
    `SUSI_ASSERT_NEXT(a_busy_after_accept, accept, state_reg != ST_IDLE, "idle after accept")
    `SUSI_ASSERT_NEXT(a_count_step, 1'b1, count_reg == $past(count_reg) || count_reg == '0 || count_reg == $past(count_reg) + CNT_W'(1), "count jumped")

endmodule

// ===== hdl/sorted_unique_index_set_unit.sv =====
// channel   dir  tdata                                      tuser      tlast
// s_*       in   row_index[15:0] position[25:16]            func[1:0]  last_of_batch
// m_*       out  count, was_new, overflow, read_value       -          batch_done
//
// one transaction in, one out
// clear, unused code: direct; read: lookup; insert: search, shift and write if new and not full
// an insert is bound by the shift of held entries through the store's single write port
// rst_n clears the count; store contents are never used before written
// s_tready stays low while a transaction is in work; a result waits in the output register
module sorted_unique_index_set_unit
    import susi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // row_index[15:0], position[25:16], rest unused
    input  logic [1:0]  s_tuser,  // func[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // count[10:0], was_new[11], overflow[12], read_value[28:13], zero
    output logic        m_tlast
);

    logic res_valid;
    logic res_ready;
    res_t res;
    logic out_valid_reg, out_valid_next;
    res_t out_reg;

    susi_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .func          (s_tuser),
        .row_index     (s_tdata[15:0]),
        .position      (s_tdata[25:16]),
        .last_of_batch (s_tlast),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.batch_done;
    assign m_tdata  = {3'b000, out_reg.read_value, out_reg.overflow, out_reg.was_new,
                       OCNT_W'(out_reg.count)};

endmodule

// ===== bench/sorted_unique_index_set_unit_tb.sv =====
module sorted_unique_index_set_unit_tb;
    import susi_pkg::*;

    localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;
    localparam int QUIET_LIMIT = 40000;
    localparam int RANDOM_OPS  = 580;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  row_index;
        logic [POS_W-1:0]  position;
        logic              last_of_batch;
        bit                drain_first;
    } row_op_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    row_op_t     pending_ops[$];
    res_t        predicted_replies[$];
    row_op_t     drv_op;
    bit          drv_busy = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;
    logic [15:0] rx_pattern = 16'hffff;
    int          quiet_cycles = 0;
    int          errors = 0;

    // predictor copy of the sorted set
    logic [KEY_W-1:0] held_rows[MAX_ROWS];
    int               held_total = 0;
    logic [KEY_W-1:0] fill_keys[MAX_ROWS];

    sorted_unique_index_set_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic res_t apply_row_op(input row_op_t op);
        res_t r;
        int   lo;
        int   hi;
        int   mid;
        int   k;
        r = '0;
        r.batch_done = op.last_of_batch;
        case (op.func)
            FN_INSERT:
            begin
                lo = 0;
                hi = held_total;
                while (lo < hi)
                begin
                    mid = (lo + hi) / 2;
                    if (held_rows[mid] < op.row_index)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (!(lo < held_total && held_rows[lo] == op.row_index))
                begin
                    r.was_new = 1'b1;
                    if (held_total >= MAX_ROWS)
                        r.overflow = 1'b1;
                    else
                    begin
                        for (k = held_total; k > lo; k--)
                            held_rows[k] = held_rows[k-1];
                        held_rows[lo] = op.row_index;
                        held_total++;
                    end
                end
            end
            FN_CLEAR:
                held_total = 0;
            FN_READ:
                if (int'(op.position) < held_total)
                    r.read_value = held_rows[op.position];
            default:
                ;
        endcase
        r.count = held_total[CNT_W-1:0];
        return r;
    endfunction

    task automatic add_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] row,
                          input logic [POS_W-1:0] pos, input logic last, input bit drain);
        row_op_t op;
        op.func          = f;
        op.row_index     = row;
        op.position      = pos;
        op.last_of_batch = last;
        op.drain_first   = drain;
        pending_ops.push_back(op);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // input side
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted_replies.push_back(apply_row_op(drv_op));
            drv_busy <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : drive_ops
        row_op_t op;
        if (rst_n && !drv_busy)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].drain_first || predicted_replies.size() == 0))
            begin
                op = pending_ops.pop_front();
                drv_op   <= op;
                s_tdata  <= {6'b0, op.position, op.row_index};
                s_tuser  <= op.func;
                s_tlast  <= op.last_of_batch;
                s_tvalid <= 1'b1;
                drv_busy <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(50, 400);
                rx_pattern   <= 16'($urandom_range(1, 65535));
            end
            else
            begin
                rx_mode_left <= rx_mode_left - 1;
                rx_pattern   <= {rx_pattern[0], rx_pattern[15:1]};
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= rx_pattern[0];
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_replies
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_replies.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                check_field("count", int'(want.count), int'(m_tdata[10:0]));
                check_field("was_new", int'(want.was_new), int'(m_tdata[11]));
                check_field("overflow", int'(want.overflow), int'(m_tdata[12]));
                check_field("read_value", int'(want.read_value), int'(m_tdata[28:13]));
                check_field("batch_done", int'(want.batch_done), int'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int               i;
        int               j;
        int               len;
        int               pick;
        int               rand_ops;
        bit               narrow;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] tmp;

        // directed: empty set, extremes, duplicates, reads past the end, unused code
        add_op(FN_READ, 16'h0000, 10'd0, 1'b0, 1'b0);
        add_op(FN_READ, 16'hffff, 10'd1023, 1'b0, 1'b0);
        add_op(FN_NOP, 16'hffff, 10'd1023, 1'b1, 1'b0);
        add_op(FN_INSERT, 16'h8000, 10'd0, 1'b0, 1'b0);
        add_op(FN_INSERT, 16'h0000, 10'd1023, 1'b0, 1'b0);
        add_op(FN_INSERT, 16'hffff, 10'd0, 1'b1, 1'b0);
        add_op(FN_INSERT, 16'h0000, 10'd0, 1'b0, 1'b0);
        add_op(FN_INSERT, 16'hffff, 10'd0, 1'b0, 1'b0);
        add_op(FN_INSERT, 16'h7fff, 10'd0, 1'b1, 1'b0);
        for (i = 0; i < 5; i++)
            add_op(FN_READ, 16'h0000, i[POS_W-1:0], 1'b0, 1'b0);
        add_op(FN_READ, 16'h0000, 10'd1023, 1'b1, 1'b0);
        add_op(FN_NOP, 16'h0000, 10'd0, 1'b0, 1'b0);
        add_op(FN_CLEAR, 16'h0000, 10'd0, 1'b1, 1'b0);
        add_op(FN_READ, 16'h0000, 10'd0, 1'b0, 1'b0);
        add_op(FN_INSERT, 16'h5555, 10'h155, 1'b0, 1'b0);
        add_op(FN_INSERT, 16'haaaa, 10'h2aa, 1'b1, 1'b1);
        add_op(FN_READ, 16'h0000, 10'd1, 1'b0, 1'b0);
        add_op(FN_CLEAR, 16'hffff, 10'd1023, 1'b0, 1'b0);

        // fill to capacity in shuffled order, one key per block of 64
        for (i = 0; i < MAX_ROWS; i++)
            fill_keys[i] = KEY_W'(i * 64 + $urandom_range(0, 63));
        for (i = MAX_ROWS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = fill_keys[i];
            fill_keys[i] = fill_keys[j];
            fill_keys[j] = tmp;
        end
        for (i = 0; i < MAX_ROWS; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                add_op(FN_READ, KEY_W'($urandom_range(0, 65535)),
                       POS_W'($urandom_range(0, 1023)), 1'b0, 1'b0);
            add_op(FN_INSERT, fill_keys[i], POS_W'($urandom_range(0, 1023)),
                   (i % 64) == 63, i == 0);
        end
        // full set: new keys dropped, duplicates still recognised
        for (i = 0; i < 3; i++)
            add_op(FN_INSERT, fill_keys[i] ^ 16'h0001 ^ (fill_keys[i] & 16'h0002),
                   10'd0, 1'b0, 1'b0);
        add_op(FN_INSERT, 16'h0000 | fill_keys[5], 10'd0, 1'b0, 1'b0);
        add_op(FN_INSERT, fill_keys[MAX_ROWS-1], 10'd0, 1'b1, 1'b0);
        add_op(FN_READ, 16'h0000, 10'd1023, 1'b0, 1'b0);
        add_op(FN_READ, 16'h0000, 10'd0, 1'b0, 1'b0);
        add_op(FN_READ, 16'h0000, 10'd512, 1'b1, 1'b0);
        add_op(FN_NOP, 16'h1234, 10'd77, 1'b0, 1'b0);
        add_op(FN_CLEAR, 16'h0000, 10'd0, 1'b1, 1'b1);

        // random batches of inserts with reads, clears and noise mixed in
        rand_ops = 0;
        while (rand_ops < RANDOM_OPS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len    = $urandom_range(1, 12);
                narrow = 1'($urandom_range(0, 1));
                base   = KEY_W'($urandom_range(0, 65535));
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        add_op(FN_READ, KEY_W'($urandom_range(0, 65535)),
                               POS_W'($urandom_range(0, 15)), 1'b0, 1'b0);
                        rand_ops++;
                    end
                    add_op(FN_INSERT,
                           narrow ? KEY_W'(base + $urandom_range(0, 15))
                                  : KEY_W'($urandom_range(0, 65535)),
                           POS_W'($urandom_range(0, 1023)), i == len - 1,
                           $urandom_range(0, 49) == 0);
                    rand_ops++;
                end
            end
            else if (pick < 82)
            begin
                add_op(FN_READ, KEY_W'($urandom_range(0, 65535)),
                       POS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, 40)),
                       1'($urandom_range(0, 1)), 1'b0);
                rand_ops++;
            end
            else if (pick < 92)
            begin
                add_op(FN_CLEAR, KEY_W'($urandom_range(0, 65535)),
                       POS_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b0);
                rand_ops++;
            end
            else
            begin
                add_op(FN_NOP, KEY_W'($urandom_range(0, 65535)),
                       POS_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b0);
                rand_ops++;
            end
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || drv_busy || predicted_replies.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && predicted_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/susi_pkg.sv
hdl/susi_ram.sv
hdl/susi_seq.sv
hdl/sorted_unique_index_set_unit.sv
bench/sorted_unique_index_set_unit_tb.sv
